>>> src/stcc_pkg.sv
// shared types and constants for the string-table container check
package stcc_pkg;

    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned WORD_BYTES   = 4;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_SHORT      = 4'd1;
    localparam logic [3:0] ERR_SIZE       = 4'd2;
    localparam logic [3:0] ERR_TABLE      = 4'd3;
    localparam logic [3:0] ERR_TOO_MANY   = 4'd4;
    localparam logic [3:0] ERR_IN_HEADER  = 4'd5;
    localparam logic [3:0] ERR_PAST_END   = 4'd6;
    localparam logic [3:0] ERR_NOT_RISING = 4'd7;
    localparam logic [3:0] ERR_NO_ZERO    = 4'd8;

    typedef struct packed {
        logic        apply;
        logic [3:0]  err;
        logic        set_win;
        logic [31:0] lo;
        logic [31:0] hi;
    } enter_res_t;

endpackage

>>> src/stcc_enter_check.sv
// offset checks and window setup when a new segment is entered
module stcc_enter_check
    import stcc_pkg::*;
(
    input  logic        active,
    input  logic        has_next,
    input  logic [31:0] off,
    input  logic [31:0] nxt,
    input  logic [34:0] hdr_end,
    input  logic [31:0] declared,
    output enter_res_t  res
);

    always_comb
    begin
        res         = '0;
        res.apply   = active;
        if ({3'b000, off} < hdr_end)
        begin
            res.err = ERR_IN_HEADER;
        end
        else if (off >= declared)
        begin
            res.err = ERR_PAST_END;
        end
        else if (has_next)
        begin
            if (nxt <= off)
            begin
                res.err = ERR_NOT_RISING;
            end
            else
            begin
                res.set_win = 1'b1;
                res.lo      = off;
                res.hi      = (nxt > declared) ? declared : nxt;
            end
        end
        else
        begin
            res.set_win = 1'b1;
            res.lo      = off;
            res.hi      = declared;
        end
    end

endmodule

>>> src/string_table_container_check_core.sv
// Streaming checker for a string-table container file. One byte is taken per
// cycle while the input is not stalled, and the single result is held in an
// output register. A byte that does not close a file is accepted while the
// result still waits; only the closing byte of the next file stalls until the
// waiting result is taken. The offset table lives
// in a single-port-write memory with a registered read; the memory is always
// read two entries ahead of the segment being scanned, and the current and
// next offsets sit in registers, so a new segment is entered without a stall.
// The memory needs no clearing pass: an entry is only read after the current
// file's table has written it.
module string_table_container_check_core
    import stcc_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       valid_res,
    output logic [3:0] error_code
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned SEG_W = $clog2(MAX_ENTRIES + 1);

    logic [31:0]      byte_count_reg, byte_count_next;
    logic [31:0]      wa_reg, wa_next;
    logic [31:0]      declared_reg, declared_next;
    logic [31:0]      count_reg, count_next;
    logic [34:0]      hdr_reg, hdr_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic             zf_reg, zf_next;
    logic [3:0]       err_reg, err_next;
    logic [31:0]      lo_reg, lo_next;
    logic [31:0]      hi_reg, hi_next;
    logic [31:0]      cur_reg, cur_next;
    logic [31:0]      nxt_reg, nxt_next;
    logic             out_valid_reg, out_valid_next;
    logic             res_valid_reg, res_valid_next;
    logic [3:0]       res_err_reg, res_err_next;

    logic [31:0]      mem [0:MAX_ENTRIES-1];
    logic [31:0]      rd_data_reg;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [31:0]      ra32;

    logic             accept;
    logic [31:0]      p;
    logic [31:0]      wa_shift;
    logic [31:0]      tbl_off;
    logic [31:0]      idx;
    logic             in_header;
    logic             in_table;
    logic             scan_ok;
    logic             in_scan;
    logic             zf_now;
    logic             seg_end;
    logic             adv;
    logic             init_go;
    logic             too_many_next;
    logic             scan_ok_next;
    logic [32:0]      seg1;
    logic [32:0]      seg2;
    logic [3:0]       fin_err;

    logic             en_active;
    logic             en_has_next;
    logic [31:0]      en_off;
    logic [31:0]      en_nxt;
    logic [34:0]      en_hdr;
    enter_res_t       en_res;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready || !last_byte;
    assign p        = byte_count_reg;
    assign wa_shift = {data_byte, wa_reg[31:8]};
    assign tbl_off  = p - 32'(HEADER_BYTES);
    assign idx      = {2'b00, tbl_off[31:2]};

    assign in_header = p < 32'(HEADER_BYTES);
    assign in_table  = !in_header && ({3'b000, p} < hdr_reg);
    assign scan_ok   = (hdr_reg <= {3'b000, declared_reg}) && (count_reg <= 32'(MAX_ENTRIES));
    assign in_scan   = !in_header && !in_table && scan_ok && (err_reg == ERR_NONE)
                       && (32'(seg_reg) < count_reg);
    assign zf_now    = zf_reg || ((p >= lo_reg) && (data_byte == 8'd0));
    assign seg_end   = ({1'b0, p} + 33'd1) == {1'b0, hi_reg};
    assign adv       = accept && in_scan && seg_end && zf_now;
    assign seg1      = 33'(seg_reg) + 33'd1;
    assign seg2      = 33'(seg_reg) + 33'd2;

    // header, table capture, offset advance and byte count
    always_comb
    begin
        byte_count_next = byte_count_reg;
        wa_next         = wa_reg;
        declared_next   = declared_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        we              = 1'b0;
        waddr           = idx[IDX_W-1:0];
        if (accept)
        begin
            if (in_header)
            begin
                wa_next = wa_shift;
                if (p == 32'd3)
                begin
                    declared_next = wa_shift;
                end
                else if (p == 32'd7)
                begin
                    count_next = wa_shift;
                end
            end
            else if (in_table)
            begin
                wa_next = wa_shift;
                if (p[1:0] == 2'b11 && idx < 32'(MAX_ENTRIES))
                begin
                    we = 1'b1;
                    if (idx == 32'd0)
                    begin
                        cur_next = wa_shift;
                    end
                    if (idx == 32'd1)
                    begin
                        nxt_next = wa_shift;
                    end
                end
            end
            else if (adv)
            begin
                cur_next = nxt_reg;
                nxt_next = rd_data_reg;
            end
            if (byte_count_reg != 32'hFFFF_FFFF)
            begin
                byte_count_next = byte_count_reg + 32'd1;
            end
        end
    end

    assign hdr_next      = 35'(HEADER_BYTES) + {1'b0, count_next, 2'b00};
    assign too_many_next = count_next > 32'(MAX_ENTRIES);
    assign scan_ok_next  = (hdr_next <= {3'b000, declared_next}) && !too_many_next;
    assign init_go       = accept && (p != 32'hFFFF_FFFF) && !in_scan
                           && (byte_count_next >= 32'(HEADER_BYTES))
                           && ({3'b000, byte_count_next} == hdr_next)
                           && scan_ok_next && (err_reg == ERR_NONE);

    always_comb
    begin
        if (init_go)
        begin
            en_active   = count_next != 32'd0;
            en_has_next = count_next > 32'd1;
            en_off      = cur_next;
            en_nxt      = nxt_next;
            en_hdr      = hdr_next;
        end
        else
        begin
            en_active   = adv && (seg1 < {1'b0, count_reg});
            en_has_next = seg2 < {1'b0, count_reg};
            en_off      = nxt_reg;
            en_nxt      = rd_data_reg;
            en_hdr      = hdr_reg;
        end
    end

    stcc_enter_check u_enter
    (
        .active   (en_active),
        .has_next (en_has_next),
        .off      (en_off),
        .nxt      (en_nxt),
        .hdr_end  (en_hdr),
        .declared (declared_next),
        .res      (en_res)
    );

    // scan state, final result and per-file restart
    always_comb
    begin
        seg_next       = seg_reg;
        zf_next        = zf_reg;
        err_next       = err_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        out_valid_next = out_valid_reg;
        res_valid_next = res_valid_reg;
        res_err_next   = res_err_reg;
        fin_err        = ERR_NONE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && in_scan)
        begin
            zf_next = zf_now;
            if (seg_end)
            begin
                if (!zf_now)
                begin
                    err_next = ERR_NO_ZERO;
                end
                else
                begin
                    seg_next = seg_reg + SEG_W'(1);
                end
            end
        end
        if (init_go)
        begin
            seg_next = '0;
        end
        if (en_res.apply)
        begin
            zf_next = 1'b0;
            if (en_res.err != ERR_NONE)
            begin
                err_next = en_res.err;
            end
            if (en_res.set_win)
            begin
                lo_next = en_res.lo;
                hi_next = en_res.hi;
            end
        end
        if (accept && last_byte)
        begin
            if (byte_count_next < 32'(HEADER_BYTES))
            begin
                fin_err = ERR_SHORT;
            end
            else if (byte_count_next != declared_next)
            begin
                fin_err = ERR_SIZE;
            end
            else if (hdr_next > {3'b000, byte_count_next})
            begin
                fin_err = ERR_TABLE;
            end
            else if (too_many_next)
            begin
                fin_err = ERR_TOO_MANY;
            end
            else if (err_next != ERR_NONE)
            begin
                fin_err = err_next;
            end
            else if (32'(seg_next) < count_next)
            begin
                fin_err = ERR_NO_ZERO;
            end
            out_valid_next = 1'b1;
            res_valid_next = fin_err == ERR_NONE;
            res_err_next   = fin_err;
            seg_next       = '0;
            zf_next        = 1'b0;
            err_next       = ERR_NONE;
            lo_next        = '0;
            hi_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            wa_reg         <= '0;
            declared_reg   <= '0;
            count_reg      <= '0;
            hdr_reg        <= 35'(HEADER_BYTES);
            seg_reg        <= '0;
            zf_reg         <= 1'b0;
            err_reg        <= ERR_NONE;
            lo_reg         <= '0;
            hi_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (accept && last_byte)
        begin
            byte_count_reg <= '0;
            wa_reg         <= '0;
            declared_reg   <= '0;
            count_reg      <= '0;
            hdr_reg        <= 35'(HEADER_BYTES);
            seg_reg        <= seg_next;
            zf_reg         <= zf_next;
            err_reg        <= err_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            out_valid_reg  <= out_valid_next;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            wa_reg         <= wa_next;
            declared_reg   <= declared_next;
            count_reg      <= count_next;
            hdr_reg        <= hdr_next;
            seg_reg        <= seg_next;
            zf_reg         <= zf_next;
            err_reg        <= err_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        res_valid_reg <= res_valid_next;
        res_err_reg   <= res_err_next;
    end

    // offset store, read two entries ahead of the scanned segment
    assign ra32  = 32'(seg_next) + 32'd2;
    assign raddr = ra32[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wa_shift;
        end
        if (we && waddr == raddr)
        begin
            rd_data_reg <= wa_shift;
        end
        else if (ra32 < 32'(MAX_ENTRIES))
        begin
            rd_data_reg <= mem[raddr];
        end
        else
        begin
            rd_data_reg <= '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign valid_res  = res_valid_reg;
    assign error_code = res_err_reg;

endmodule

>>> tb/testbench.sv
// testbench for the string-table container check: directed and random files, checked against a predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stcc_pkg::*;

    localparam int unsigned DEPTH = 1024;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct {
        logic       ok;
        logic [3:0] code;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic       valid_res;
    logic [3:0] error_code;

    byte_item_t pending_bytes[$];
    verdict_t   expected_verdicts[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_send;
    int         fail_count;
    int         items_made;

    // predictor state
    logic [31:0] p_count;
    logic [31:0] p_word;
    logic [31:0] p_total;
    logic [31:0] p_entries;
    logic [31:0] p_offsets[DEPTH];
    logic [31:0] p_seg;
    logic        p_zero;
    logic [3:0]  p_err;
    logic [31:0] p_lo;
    logic [31:0] p_hi;

    string_table_container_check_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .last_byte(last_byte),
        .out_valid(out_valid), .out_ready(out_ready),
        .valid_res(valid_res), .error_code(error_code)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [32:0] header_len();
        return 33'(HEADER_BYTES) + {1'b0, p_entries} * 33'(WORD_BYTES);
    endfunction

    function automatic bit scan_ok();
        return header_len() <= {1'b0, p_total} && p_entries <= DEPTH;
    endfunction

    function automatic void clear_predictor();
        p_count = '0; p_word = '0; p_total = '0; p_entries = '0;
        p_seg = '0; p_zero = 1'b0; p_err = ERR_NONE; p_lo = '0; p_hi = '0;
    endfunction

    function automatic void open_segment();
        logic [31:0] off;
        logic [31:0] nxt;
        if (p_seg >= p_entries || p_seg >= DEPTH)
            return;
        off = p_offsets[p_seg];
        p_zero = 1'b0;
        if ({1'b0, off} < header_len())
            p_err = ERR_IN_HEADER;
        else if (off >= p_total)
            p_err = ERR_PAST_END;
        else if (p_seg + 1 < p_entries && p_seg + 1 < DEPTH)
        begin
            nxt = p_offsets[p_seg + 1];
            if (nxt <= off)
                p_err = ERR_NOT_RISING;
            else
            begin
                p_lo = off;
                p_hi = (nxt > p_total) ? p_total : nxt;
            end
        end
        else
        begin
            p_lo = off;
            p_hi = p_total;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [31:0] pos;
        logic [31:0] idx;
        logic [3:0]  code;
        verdict_t    v;
        pos = p_count;
        if (pos < HEADER_BYTES)
        begin
            p_word = {b, p_word[31:8]};
            if (pos == 3) p_total = p_word;
            else if (pos == 7) p_entries = p_word;
        end
        else if ({1'b0, pos} < header_len())
        begin
            p_word = {b, p_word[31:8]};
            if (pos[1:0] == 2'd3)
            begin
                idx = (pos - HEADER_BYTES) >> 2;
                if (idx < DEPTH) p_offsets[idx] = p_word;
            end
        end
        else if (scan_ok() && p_err == ERR_NONE && p_seg < p_entries)
        begin
            if (pos >= p_lo && b == 8'd0) p_zero = 1'b1;
            if (pos + 1 == p_hi)
            begin
                if (!p_zero) p_err = ERR_NO_ZERO;
                else
                begin
                    p_seg++;
                    open_segment();
                end
            end
        end
        if (p_count != 32'hFFFF_FFFF) p_count++;
        if (pos != 32'hFFFF_FFFF && p_count >= HEADER_BYTES
            && {1'b0, p_count} == header_len() && scan_ok() && p_err == ERR_NONE)
        begin
            p_seg = '0;
            open_segment();
        end
        if (last)
        begin
            if (p_count < HEADER_BYTES) code = ERR_SHORT;
            else if (p_count != p_total) code = ERR_SIZE;
            else if (header_len() > {1'b0, p_count}) code = ERR_TABLE;
            else if (p_entries > DEPTH) code = ERR_TOO_MANY;
            else if (p_err != ERR_NONE) code = p_err;
            else if (p_seg < p_entries) code = ERR_NO_ZERO;
            else code = ERR_NONE;
            v.ok = (code == ERR_NONE);
            v.code = code;
            expected_verdicts.push_back(v);
            clear_predictor();
        end
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last);
        byte_item_t it;
        it.data = b;
        it.last = last;
        pending_bytes.push_back(it);
        items_made++;
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            push_byte(w[8*i +: 8], 1'b0);
    endfunction

    // builds a file; mode 0 well formed, else a random corruption
    function automatic void make_file(int n, int mode);
        logic [31:0] offs[$];
        int seg_len[$];
        int hdr;
        int total;
        int at;
        int k;
        logic [7:0] body[$];
        hdr = 8 + 4 * n;
        total = hdr;
        for (int i = 0; i < n; i++)
        begin
            seg_len.push_back($urandom_range(1, 6));
            offs.push_back(total);
            total += seg_len[i];
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < seg_len[i]; j++)
                body.push_back((j == seg_len[i] - 1) ? 8'd0 : 8'($urandom_range(1, 255)));
        if (n > 0)
        begin
            k = $urandom_range(0, n - 1);
            case (mode)
                1: offs[k] = $urandom_range(0, hdr - 1);
                2: offs[k] = total + $urandom_range(0, 3);
                3: if (k > 0) offs[k] = offs[k - 1] - $urandom_range(0, 1);
                4: begin
                    at = offs[k] - hdr;
                    for (int j = 0; j < seg_len[k]; j++)
                        body[at + j] = 8'($urandom_range(1, 255));
                end
                default: ;
            endcase
        end
        if (mode == 5) total += $urandom_range(0, 1) ? 1 : -1;
        push_word(total);
        push_word(n);
        foreach (offs[i]) push_word(offs[i]);
        foreach (body[i]) push_byte(body[i], i == body.size() - 1);
        if (n == 0) pending_bytes[$].last = 1'b1;
    endfunction

    function automatic void make_noise();
        int len;
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom), i == len - 1);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_byte(data_byte, last_byte);
            if (pending_bytes.size() > 0 && !hold_send
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                data_byte <= pending_bytes[0].data;
                last_byte <= pending_bytes[0].last;
                void'(pending_bytes.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result valid_res=%0d error_code=%0d",
                           valid_res, error_code);
                    fail_count++;
                end
                else
                begin
                    if (valid_res !== expected_verdicts[0].ok)
                    begin
                        $error("valid_res expected %0d actual %0d",
                               expected_verdicts[0].ok, valid_res);
                        fail_count++;
                    end
                    if (error_code !== expected_verdicts[0].code)
                    begin
                        $error("error_code expected %0d actual %0d",
                               expected_verdicts[0].code, error_code);
                        fail_count++;
                    end
                    void'(expected_verdicts.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        while (pending_bytes.size() > 0 || in_valid || expected_verdicts.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        fail_count = 0;
        items_made = 0;
        hold_send = 1'b0;
        send_idle_pct = 12;
        recv_idle_pct = 88;
        clear_predictor();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: short files, empty table, extremes, and a file of each corruption mode
        push_byte(8'hFF, 1'b1);
        push_word(32'd8); push_word(32'd0); pending_bytes[$].last = 1'b1;
        push_word(32'hFFFF_FFFF); push_word(32'hFFFF_FFFF); pending_bytes[$].last = 1'b1;
        push_word(32'd12); push_word(32'd1025); pending_bytes[$].last = 1'b1;
        push_word(32'd8); push_word(32'd0); push_byte(8'hFF, 1'b1);
        for (int m = 0; m <= 5; m++) make_file(2, m);
        drain();

        // sender pause until every result is in
        make_file(3, 0);
        while (pending_bytes.size() > 0)
            @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        hold_send = 1'b0;
        make_file(2, 0);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 12 : 0;
            items_made = 0;
            while (items_made < 110)
            begin
                if ($urandom_range(0, 9) == 0) make_noise();
                else make_file($urandom_range(0, 5),
                               ($urandom_range(0, 1) ? 0 : $urandom_range(1, 5)));
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
